// ===== sv/bcr_pkg.sv =====
// Package for the bicubic Catmull-Rom interpolator: widths, datapath sizing and sequencer states.
// No dependencies; imported by the top level.
package bcr_pkg;

  // Port field widths
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned PVAL_W = 16;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned OUT_W  = 17;

  // Arithmetic sizing
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned FRAC_WIDTH   = 16;
  localparam int unsigned NUM_POINTS   = 16;

  // Datapath word: sample, fraction and headroom for Horner overshoot
  localparam int unsigned ACC_W = SAMPLE_WIDTH + FRAC_WIDTH + 8;
  localparam int unsigned HI_W  = ACC_W - FRAC_WIDTH;
  localparam int unsigned MA_W  = (HI_W > FRAC_WIDTH + 1) ? HI_W : FRAC_WIDTH + 1;
  localparam int unsigned MB_W  = FRAC_WIDTH + 1;
  localparam int unsigned PROD_W = MA_W + MB_W;
  localparam int unsigned RND_W = ACC_W - FRAC_WIDTH;

  // Horner step codes
  localparam logic [1:0] STEP_B   = 2'd0;
  localparam logic [1:0] STEP_C   = 2'd1;
  localparam logic [1:0] STEP_FIN = 2'd2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COEF,
    ST_MUL_LO,
    ST_MUL_HI
  } state_e;

endpackage

// ===== sv/bicubic_catmull_rom_interpolator.sv =====
// Top level of the bicubic Catmull-Rom interpolator: sequencer, shared multiplier datapath.
// Depends on bcr_pkg and bcr_ram.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------------------------
//  command   | in        | start && !busy         | opcode_i, point_index_i, point_value_i,
//            |           |                        | frac_x_i, frac_y_i
//  result    | out       | done_o, one cycle      | interp_value_o
//
// A store transaction writes the point RAM at the accepting edge; busy stays low, so a new
// command can follow in the next cycle. An evaluate transaction runs, per column, the RAM
// reads, a coefficient step and 3 Horner multiplies, each a low and a high phase on the one
// shared multiplier, then the same along x without the reads. The shared multiplier and the
// single RAM read port set the length of an evaluation.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle; the point RAM is not
// cleared. The receiver cannot stall: the result is shown for exactly one cycle.
module bicubic_catmull_rom_interpolator
  import bcr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    opcode_i,
  input  logic [IDX_W-1:0]        point_index_i,
  input  logic signed [PVAL_W-1:0] point_value_i,
  input  logic [FRAC_W-1:0]       frac_x_i,
  input  logic [FRAC_W-1:0]       frac_y_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] interp_value_o
);

  localparam int unsigned AW = $clog2(NUM_POINTS);

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e     state_q, state_d;
  logic [1:0] xi_q, xi_d;        // column being reduced
  logic [1:0] step_q, step_d;    // Horner step
  logic [2:0] rd_cnt_q, rd_cnt_d;// RAM read issue/capture counter, 0..4
  logic       pass_q, pass_d;    // 0: columns along y, 1: final cubic along x
  logic       done_q, done_d;

  // ---------------------------------------------------------------------------
  // Datapath registers (payload, no reset)
  // ---------------------------------------------------------------------------
  logic [FRAC_WIDTH-1:0]   ux_q, uy_q;
  logic signed [ACC_W-1:0] q_q [4];      // current control values
  logic signed [ACC_W-1:0] col_q [3];    // finished column values
  logic signed [ACC_W-1:0] h_q, b_q, c_q;
  logic [FRAC_WIDTH-1:0]   lo_q;         // floor(lo * u / 2^F) from the low phase
  logic signed [OUT_W-1:0] out_q;

  logic accept, store_we;
  assign accept   = start && !busy;
  assign store_we = accept && (opcode_i == OP_STORE);
  assign busy     = (state_q != ST_IDLE);

  // ---------------------------------------------------------------------------
  // Point store
  // ---------------------------------------------------------------------------
  logic [AW-1:0]           raddr;
  logic [SAMPLE_WIDTH-1:0] rdata;

  assign raddr = AW'({xi_q, rd_cnt_q[1:0]});

  bcr_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (NUM_POINTS)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (AW'(point_index_i)),
    .wdata_i (point_value_i[SAMPLE_WIDTH-1:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sample to datapath scale: sign extend, FRAC_WIDTH zero fraction bits
  logic signed [ACC_W-1:0] rd_scaled;
  assign rd_scaled = {{(ACC_W-SAMPLE_WIDTH-FRAC_WIDTH){rdata[SAMPLE_WIDTH-1]}}, rdata,
                      {FRAC_WIDTH{1'b0}}};

  // ---------------------------------------------------------------------------
  // Catmull-Rom coefficients from the four control values
  //   a = 3(p1-p2)+p3-p0, b = 2p0-5p1+4p2-p3, c = p2-p0
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] d12, coef_a, coef_b, coef_c;
  assign d12    = q_q[1] - q_q[2];
  assign coef_a = d12 + (d12 <<< 1) + q_q[3] - q_q[0];
  assign coef_b = (q_q[0] <<< 1) - q_q[1] - (q_q[1] <<< 2) + (q_q[2] <<< 2) - q_q[3];
  assign coef_c = q_q[2] - q_q[0];

  // ---------------------------------------------------------------------------
  // Shared multiplier: h*u split as hi*u + floor(lo*u / 2^F), a low and a high phase per product
  // ---------------------------------------------------------------------------
  logic [FRAC_WIDTH-1:0]    u_sel;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [HI_W-1:0]   h_hi;

  assign u_sel = pass_q ? ux_q : uy_q;
  assign h_hi  = h_q[ACC_W-1:FRAC_WIDTH];

  always_comb begin
    if (state_q == ST_MUL_LO) begin
      mul_a = signed'(MA_W'({1'b0, h_q[FRAC_WIDTH-1:0]}));
    end else begin
      mul_a = MA_W'(h_hi);
    end
  end

  assign mul_b = signed'({1'b0, u_sel});
  assign prod  = mul_a * mul_b;

  logic signed [ACC_W-1:0] hu;       // floor(h*u / 2^F)
  logic signed [ACC_W-1:0] horner;   // next Horner value
  logic signed [ACC_W-1:0] cubic;    // p1 + floor(h*u/2^F / 2)

  assign hu     = ACC_W'(prod) + signed'(ACC_W'({1'b0, lo_q}));
  assign horner = hu + ((step_q == STEP_B) ? b_q : c_q);
  assign cubic  = q_q[1] + (hu >>> 1);

  // Round to nearest, ties up, then clamp to the output range
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [RND_W-1:0] rnd;
  logic signed [OUT_W-1:0] rnd_sat;
  localparam logic signed [RND_W-1:0] LIM_HI = RND_W'((1 << SAMPLE_WIDTH) - 1);
  localparam logic signed [RND_W-1:0] LIM_LO = -RND_W'(1 << SAMPLE_WIDTH);

  assign rnd_sum = cubic + signed'(ACC_W'(1 << (FRAC_WIDTH - 1)));
  assign rnd     = rnd_sum[ACC_W-1:FRAC_WIDTH];

  always_comb begin
    priority if (rnd > LIM_HI) begin
      rnd_sat = OUT_W'(LIM_HI);
    end else if (rnd < LIM_LO) begin
      rnd_sat = OUT_W'(LIM_LO);
    end else begin
      rnd_sat = OUT_W'(rnd);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    xi_d     = xi_q;
    step_d   = step_q;
    rd_cnt_d = rd_cnt_q;
    pass_d   = pass_q;
    done_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (opcode_i == OP_EVAL)) begin
          state_d  = ST_LOAD;
          xi_d     = '0;
          rd_cnt_d = '0;
          pass_d   = 1'b0;
        end
      end
      ST_LOAD: begin
        rd_cnt_d = rd_cnt_q + 3'd1;
        if (rd_cnt_q == 3'd4) begin
          state_d = ST_COEF;
        end
      end
      ST_COEF: begin
        step_d  = STEP_B;
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        if (step_q != STEP_FIN) begin
          step_d  = step_q + 2'd1;
          state_d = ST_MUL_LO;
        end else if (pass_q) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else if (xi_q == 2'd3) begin
          pass_d  = 1'b1;
          state_d = ST_COEF;
        end else begin
          xi_d     = xi_q + 2'd1;
          rd_cnt_d = '0;
          state_d  = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      xi_q     <= '0;
      step_q   <= STEP_B;
      rd_cnt_q <= '0;
      pass_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      xi_q     <= xi_d;
      step_q   <= step_d;
      rd_cnt_q <= rd_cnt_d;
      pass_q   <= pass_d;
      done_q   <= done_d;
    end
  end

  // Datapath updates
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ux_q <= frac_x_i[FRAC_WIDTH-1:0];
      uy_q <= frac_y_i[FRAC_WIDTH-1:0];
    end
    if ((state_q == ST_LOAD) && (rd_cnt_q != 3'd0)) begin
      q_q[2'(rd_cnt_q - 3'd1)] <= rd_scaled;
    end
    if (state_q == ST_COEF) begin
      h_q <= coef_a;
      b_q <= coef_b;
      c_q <= coef_c;
    end
    if (state_q == ST_MUL_LO) begin
      lo_q <= prod[2*FRAC_WIDTH-1:FRAC_WIDTH];
    end
    if (state_q == ST_MUL_HI) begin
      if (step_q != STEP_FIN) begin
        h_q <= horner;
      end else if (pass_q) begin
        out_q <= rnd_sat;
      end else if (xi_q == 2'd3) begin
        q_q[0] <= col_q[0];
        q_q[1] <= col_q[1];
        q_q[2] <= col_q[2];
        q_q[3] <= cubic;
      end else begin
        col_q[xi_q] <= cubic;
      end
    end
  end

  assign done_o         = done_q;
  assign interp_value_o = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_eval_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_EVAL)) |=> busy)
    else $error("evaluate transaction did not start the sequencer");

  a_store_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_STORE)) |=> !busy)
    else $error("store transaction made the block busy");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer still running");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a running evaluation");
`endif

endmodule

// ===== sv/bcr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module bcr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
